// ===== src/npyhp_pkg.sv =====
// ----------------------------------------------------------------------------
// npyhp_pkg
// Shared types, status codes and keyword tables for the NPY header parser.
// ----------------------------------------------------------------------------
package npyhp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [4:0]  status;
    logic [1:0]  dtype;
    logic [3:0]  dim_count;
    logic [2:0]  dim_index;
    logic [31:0] dim_value;
    logic [47:0] element_count;
    logic [32:0] payload_offset;
    logic        last_result;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic zero_prod;
    logic mul_start;
    logic mul_step;
    logic mul_commit;
    logic count_err;
    logic pay_check;
    logic emit_next;
    logic clear;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic early_bad;
    logic dim_end;
    logic dim_zero;
    logic mul_done;
    logic mul_ovf;
    logic emit_last;
  } sts_t;

  localparam logic [4:0] STAT_OK        = 5'd0;
  localparam logic [4:0] STAT_SMALL     = 5'd1;
  localparam logic [4:0] STAT_MAGIC     = 5'd2;
  localparam logic [4:0] STAT_MINOR     = 5'd3;
  localparam logic [4:0] STAT_MAJOR     = 5'd4;
  localparam logic [4:0] STAT_TRUNC     = 5'd5;
  localparam logic [4:0] STAT_NEWLINE   = 5'd6;
  localparam logic [4:0] STAT_NONASCII  = 5'd7;
  localparam logic [4:0] STAT_SYNTAX    = 5'd8;
  localparam logic [4:0] STAT_KEY       = 5'd9;
  localparam logic [4:0] STAT_MISSING   = 5'd10;
  localparam logic [4:0] STAT_FORTRAN   = 5'd11;
  localparam logic [4:0] STAT_DESCR     = 5'd12;
  localparam logic [4:0] STAT_DIMOVF    = 5'd13;
  localparam logic [4:0] STAT_COUNT     = 5'd14;
  localparam logic [4:0] STAT_PAYLOAD   = 5'd15;
  localparam logic [4:0] STAT_DIMS      = 5'd16;

  localparam int MAX_RESULTS = 8;

  // keyword indexes
  localparam logic [3:0] WD_DESCR   = 4'd0;
  localparam logic [3:0] WD_FORTRAN = 4'd1;
  localparam logic [3:0] WD_SHAPE   = 4'd2;
  localparam logic [3:0] WD_F8      = 4'd3;
  localparam logic [3:0] WD_I8      = 4'd4;
  localparam logic [3:0] WD_I4      = 4'd5;
  localparam logic [3:0] WD_B1      = 4'd6;
  localparam logic [3:0] WD_TRUE    = 4'd7;
  localparam logic [3:0] WD_FALSE   = 4'd8;

  function automatic logic [3:0] word_len(input logic [3:0] w);
    logic [3:0] n;
    unique case (w)
      WD_DESCR:   n = 4'd5;
      WD_FORTRAN: n = 4'd13;
      WD_SHAPE:   n = 4'd5;
      WD_F8, WD_I8, WD_I4, WD_B1: n = 4'd3;
      WD_TRUE:    n = 4'd4;
      WD_FALSE:   n = 4'd5;
      default:    n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input logic [3:0] w, input logic [3:0] p);
    logic [0:12][7:0] s;
    s = '0;
    unique case (w)
      WD_DESCR:   s = {"descr", 64'd0};
      WD_FORTRAN: s = "fortran_order";
      WD_SHAPE:   s = {"shape", 64'd0};
      WD_F8:      s = {"<f8", 80'd0};
      WD_I8:      s = {"<i8", 80'd0};
      WD_I4:      s = {"<i4", 80'd0};
      WD_B1:      s = {"|b1", 80'd0};
      WD_TRUE:    s = {"True", 72'd0};
      WD_FALSE:   s = {"False", 64'd0};
      default:    s = '0;
    endcase
    return (p < 4'd13) ? s[p] : 8'd0;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h93;
      3'd1:    b = 8'h4E;
      3'd2:    b = 8'h55;
      3'd3:    b = 8'h4D;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h59;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/npyhp_dpath.sv =====
// ----------------------------------------------------------------------------
// npyhp_dpath
// Byte parser state, dimension store, shift-add count multiplier and
// result formatting.
// ----------------------------------------------------------------------------
module npyhp_dpath #(
  parameter int MAX_DIMS   = 8,
  parameter int DIM_BITS   = 32,
  parameter int COUNT_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  npyhp_pkg::in_t    byte_data,
  input  npyhp_pkg::cmd_t   cmd,
  output npyhp_pkg::sts_t   sts,
  output npyhp_pkg::out_t   result_data
);

  localparam int DW = $clog2(MAX_DIMS + 1);
  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int MW = COUNT_BITS + DIM_BITS;
  localparam logic [51:0] POS_MAX = {52{1'b1}};

  localparam logic [2:0] PH_MAGIC   = 3'd0;
  localparam logic [2:0] PH_VERSION = 3'd1;
  localparam logic [2:0] PH_HLEN    = 3'd2;
  localparam logic [2:0] PH_HEADER  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [3:0] PS_OPEN        = 4'd0;
  localparam logic [3:0] PS_KEY_OR_CLOSE = 4'd1;
  localparam logic [3:0] PS_KEY_STR     = 4'd2;
  localparam logic [3:0] PS_COLON       = 4'd3;
  localparam logic [3:0] PS_DESCR_Q     = 4'd4;
  localparam logic [3:0] PS_DESCR_STR   = 4'd5;
  localparam logic [3:0] PS_BOOL        = 4'd6;
  localparam logic [3:0] PS_SHAPE_OPEN  = 4'd7;
  localparam logic [3:0] PS_SHAPE_ITEM  = 4'd8;
  localparam logic [3:0] PS_SHAPE_NUM   = 4'd9;
  localparam logic [3:0] PS_SHAPE_SEP   = 4'd10;
  localparam logic [3:0] PS_AFTER_VAL   = 4'd11;
  localparam logic [3:0] PS_DONE        = 4'd12;
  localparam logic [3:0] PS_FAIL        = 4'd13;

  localparam logic [1:0] KEY_DESCR   = 2'd0;
  localparam logic [1:0] KEY_FORTRAN = 2'd1;
  localparam logic [1:0] KEY_SHAPE   = 2'd2;
  localparam logic [1:0] KEY_NONE    = 2'd3;

  localparam logic [2:0] DT_UNKNOWN = 3'd4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // per-file parser state
  logic [2:0]          phase,      phase_next;
  logic [51:0]         bpos,       bpos_next;
  logic [1:0]          major,      major_next;
  logic [31:0]         hlen,       hlen_next;
  logic [31:0]         hleft,      hleft_next;
  logic [3:0]          ps,         ps_next;
  logic                quote,      quote_next;
  logic [3:0]          mbits,      mbits_next;
  logic [3:0]          spos,       spos_next;
  logic [2:0]          kflags,     kflags_next;
  logic                fortran,    fortran_next;
  logic [2:0]          dtc,        dtc_next;
  logic [DIM_BITS-1:0] acc,        acc_next;
  logic [DW-1:0]       dims_seen,  dims_seen_next;
  logic [4:0]          first_err,  first_err_next;
  logic                nasc,       nasc_next;
  logic [4:0]          pend,       pend_next;
  logic [1:0]          key_code,   key_code_next;

  logic [DIM_BITS-1:0] dim_store [MAX_DIMS];
  logic                store_we;

  // end-of-file evaluation
  logic [4:0]            res_status;
  logic [COUNT_BITS-1:0] prod;
  logic [DW-1:0]         idx;
  logic [MW-1:0]         mc;
  logic [MW-1:0]         macc;
  logic [DIM_BITS-1:0]   mplier;

  logic [7:0]          c;
  logic                is_sp, is_q, is_dig, closes;
  logic [3:0]          dig;
  logic [DIM_BITS+3:0] acc10;
  logic                acc_ovf;
  logic [3:0]          base;
  logic [2:0]          ncand;
  logic [3:0]          step_bits;
  logic [3:0]          spos_inc;
  logic                fin_hit;
  logic [1:0]          fin_k;
  logic [31:0]         hlen_ins;
  logic                hlen_last;
  logic [4:0]          fin_code;
  logic [4:0]          early_status;
  logic [DIM_BITS-1:0] rd;
  logic [3:0]          start;
  logic [32:0]         offset;
  logic [51:0]         avail;
  logic [51:0]         avail_sh;
  logic                short_pay;
  logic [6:0]          dims7;
  logic [6:0]          nres;
  logic [63:0]         dv64;
  logic [63:0]         cnt64;

  assign c      = byte_data.data_byte;
  assign is_sp  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF);
  assign is_q   = (c == CH_SQUOTE) || (c == CH_DQUOTE);
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign closes = (c == (quote ? CH_DQUOTE : CH_SQUOTE));
  assign dig    = c[3:0];

  // acc*10 + digit; overflow when the high bits are set
  assign acc10   = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (DIM_BITS + 4)'(dig);
  assign acc_ovf = (acc10[DIM_BITS+3:DIM_BITS] != 4'd0);

  assign spos_inc = (spos < 4'd15) ? spos + 4'd1 : spos;

  // keyword candidate matcher
  always_comb begin
    logic [3:0] w;
    unique case (ps)
      PS_KEY_STR:   begin base = npyhp_pkg::WD_DESCR; ncand = 3'd3; end
      PS_DESCR_STR: begin base = npyhp_pkg::WD_F8;    ncand = 3'd4; end
      PS_BOOL:      begin base = npyhp_pkg::WD_TRUE;  ncand = 3'd2; end
      default:      begin base = 4'd0;                ncand = 3'd0; end
    endcase
    step_bits = mbits;
    fin_hit   = 1'b0;
    fin_k     = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      w = base + 4'(k);
      if (3'(k) < ncand) begin
        step_bits[k] = mbits[k] && (spos < npyhp_pkg::word_len(w)) &&
                       (npyhp_pkg::word_char(w, spos) == c);
        if (mbits[k] && (spos == npyhp_pkg::word_len(w))) begin
          fin_hit = 1'b1;
          fin_k   = 2'(k);
        end
      end
    end
  end

  always_comb begin
    hlen_ins = hlen;
    hlen_ins[{bpos[1:0], 3'b000} +: 8] = c;
  end
  assign hlen_last = (bpos[1:0] == ((major == 2'd1) ? 2'd1 : 2'd3));

  // check at the final header byte; count check is deferred to end of file
  always_comb begin
    if (c != CH_NL)                 fin_code = npyhp_pkg::STAT_NEWLINE;
    else if (nasc)                  fin_code = npyhp_pkg::STAT_NONASCII;
    else if (ps == PS_FAIL)         fin_code = pend;
    else if (ps != PS_DONE)         fin_code = npyhp_pkg::STAT_SYNTAX;
    else if (kflags != 3'b111)      fin_code = npyhp_pkg::STAT_MISSING;
    else if (fortran)               fin_code = npyhp_pkg::STAT_FORTRAN;
    else if (dtc > 3'd3)            fin_code = npyhp_pkg::STAT_DESCR;
    else                            fin_code = npyhp_pkg::STAT_OK;
  end

  always_comb begin
    phase_next     = phase;
    bpos_next      = (bpos != POS_MAX) ? bpos + 52'd1 : bpos;
    major_next     = major;
    hlen_next      = hlen;
    hleft_next     = hleft;
    ps_next        = ps;
    quote_next     = quote;
    mbits_next     = mbits;
    spos_next      = spos;
    kflags_next    = kflags;
    fortran_next   = fortran;
    dtc_next       = dtc;
    acc_next       = acc;
    dims_seen_next = dims_seen;
    first_err_next = first_err;
    nasc_next      = nasc;
    pend_next      = pend;
    key_code_next  = key_code;
    store_we       = 1'b0;

    if (first_err == npyhp_pkg::STAT_OK) begin
      case (phase)
        PH_MAGIC: begin
          if (c != npyhp_pkg::magic_byte(bpos[2:0])) first_err_next = npyhp_pkg::STAT_MAGIC;
          else if (bpos[2:0] == 3'd5) phase_next = PH_VERSION;
        end
        PH_VERSION: begin
          if (!bpos[0]) begin
            major_next = (c >= 8'd1 && c <= 8'd3) ? c[1:0] : 2'd0;
          end else if (c != 8'd0) begin
            first_err_next = npyhp_pkg::STAT_MINOR;
          end else if (major == 2'd0) begin
            first_err_next = npyhp_pkg::STAT_MAJOR;
          end else begin
            phase_next = PH_HLEN;
            hlen_next  = 32'd0;
          end
        end
        PH_HLEN: begin
          hlen_next = hlen_ins;
          if (hlen_last) begin
            phase_next = PH_HEADER;
            hleft_next = hlen_ins;
            if (hlen_ins == 32'd0) first_err_next = npyhp_pkg::STAT_NEWLINE;
          end
        end
        PH_HEADER: begin
          if (hleft > 32'd1) begin
            hleft_next = hleft - 32'd1;
            if (major != 2'd3 && c[7]) nasc_next = 1'b1;
            case (ps)
              PS_OPEN: begin
                if (!is_sp) begin
                  if (c == CH_LBRACE) ps_next = PS_KEY_OR_CLOSE;
                  else begin pend_next = npyhp_pkg::STAT_SYNTAX; ps_next = PS_FAIL; end
                end
              end
              PS_AFTER_VAL, PS_KEY_OR_CLOSE: begin
                if (!is_sp) begin
                  if (c == CH_COMMA && ps == PS_AFTER_VAL) ps_next = PS_KEY_OR_CLOSE;
                  else if (c == CH_RBRACE) ps_next = PS_DONE;
                  else if (is_q) begin
                    quote_next = (c == CH_DQUOTE);
                    mbits_next = 4'hF;
                    spos_next  = 4'd0;
                    ps_next    = PS_KEY_STR;
                  end else begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end
                end
              end
              PS_KEY_STR: begin
                if (closes) begin
                  key_code_next = fin_hit ? fin_k : KEY_NONE;
                  ps_next       = PS_COLON;
                end else begin
                  mbits_next = step_bits;
                  spos_next  = spos_inc;
                end
              end
              PS_COLON: begin
                if (!is_sp) begin
                  if (c != CH_COLON) begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end else begin
                    case (key_code)
                      KEY_DESCR: ps_next = PS_DESCR_Q;
                      KEY_FORTRAN: begin
                        mbits_next = 4'b0011;
                        spos_next  = 4'd0;
                        ps_next    = PS_BOOL;
                      end
                      KEY_SHAPE: ps_next = PS_SHAPE_OPEN;
                      default: begin
                        pend_next = npyhp_pkg::STAT_KEY;
                        ps_next   = PS_FAIL;
                      end
                    endcase
                  end
                end
              end
              PS_DESCR_Q: begin
                if (!is_sp) begin
                  if (is_q) begin
                    quote_next = (c == CH_DQUOTE);
                    mbits_next = 4'hF;
                    spos_next  = 4'd0;
                    ps_next    = PS_DESCR_STR;
                  end else begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end
                end
              end
              PS_DESCR_STR: begin
                if (closes) begin
                  dtc_next    = fin_hit ? {1'b0, fin_k} : DT_UNKNOWN;
                  kflags_next = kflags | 3'b001;
                  ps_next     = PS_AFTER_VAL;
                end else begin
                  mbits_next = step_bits;
                  spos_next  = spos_inc;
                end
              end
              PS_BOOL: begin
                if (!(spos == 4'd0 && is_sp)) begin
                  mbits_next = step_bits;
                  spos_next  = spos_inc;
                  if (step_bits == 4'd0) begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end else if (step_bits[0] && spos_inc == 4'd4) begin
                    fortran_next = 1'b1;
                    kflags_next  = kflags | 3'b010;
                    ps_next      = PS_AFTER_VAL;
                  end else if (step_bits[1] && spos_inc == 4'd5) begin
                    fortran_next = 1'b0;
                    kflags_next  = kflags | 3'b010;
                    ps_next      = PS_AFTER_VAL;
                  end
                end
              end
              PS_SHAPE_OPEN: begin
                if (!is_sp) begin
                  if (c == CH_LPAREN) begin
                    dims_seen_next = '0;
                    ps_next        = PS_SHAPE_ITEM;
                  end else begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end
                end
              end
              PS_SHAPE_ITEM, PS_SHAPE_SEP: begin
                if (!is_sp) begin
                  if (c == CH_RPAREN) begin
                    kflags_next = kflags | 3'b100;
                    ps_next     = PS_AFTER_VAL;
                  end else if (is_dig) begin
                    acc_next = DIM_BITS'(dig);
                    ps_next  = PS_SHAPE_NUM;
                  end else if (c == CH_COMMA && ps == PS_SHAPE_SEP) begin
                    ps_next = PS_SHAPE_ITEM;
                  end else begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end
                end
              end
              PS_SHAPE_NUM: begin
                if (is_dig) begin
                  if (acc_ovf) begin
                    pend_next = npyhp_pkg::STAT_DIMOVF;
                    ps_next   = PS_FAIL;
                  end else begin
                    acc_next = acc10[DIM_BITS-1:0];
                  end
                end else if (32'(dims_seen) >= 32'(MAX_DIMS)) begin
                  pend_next = npyhp_pkg::STAT_DIMS;
                  ps_next   = PS_FAIL;
                end else begin
                  store_we       = 1'b1;
                  dims_seen_next = dims_seen + DW'(1);
                  if (is_sp) ps_next = PS_SHAPE_SEP;
                  else if (c == CH_COMMA) ps_next = PS_SHAPE_ITEM;
                  else if (c == CH_RPAREN) begin
                    kflags_next = kflags | 3'b100;
                    ps_next     = PS_AFTER_VAL;
                  end else begin
                    pend_next = npyhp_pkg::STAT_SYNTAX;
                    ps_next   = PS_FAIL;
                  end
                end
              end
              default: ;
            endcase
          end else begin
            first_err_next = fin_code;
            phase_next     = PH_PAYLOAD;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase     <= PH_MAGIC;
      bpos      <= '0;
      major     <= '0;
      hlen      <= '0;
      hleft     <= '0;
      ps        <= PS_OPEN;
      quote     <= 1'b0;
      mbits     <= 4'hF;
      spos      <= '0;
      kflags    <= '0;
      fortran   <= 1'b0;
      dtc       <= DT_UNKNOWN;
      acc       <= '0;
      dims_seen <= '0;
      first_err <= npyhp_pkg::STAT_OK;
      nasc      <= 1'b0;
      pend      <= npyhp_pkg::STAT_OK;
      key_code  <= KEY_NONE;
    end else if (cmd.accept) begin
      phase     <= phase_next;
      bpos      <= bpos_next;
      major     <= major_next;
      hlen      <= hlen_next;
      hleft     <= hleft_next;
      ps        <= ps_next;
      quote     <= quote_next;
      mbits     <= mbits_next;
      spos      <= spos_next;
      kflags    <= kflags_next;
      fortran   <= fortran_next;
      dtc       <= dtc_next;
      acc       <= acc_next;
      dims_seen <= dims_seen_next;
      first_err <= first_err_next;
      nasc      <= nasc_next;
      pend      <= pend_next;
      key_code  <= key_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && store_we) dim_store[dims_seen[AW-1:0]] <= acc;
  end

  assign rd = dim_store[idx[AW-1:0]];

  always_comb begin
    if (bpos < 52'd10)                       early_status = npyhp_pkg::STAT_SMALL;
    else if (first_err != npyhp_pkg::STAT_OK) early_status = first_err;
    else if (phase != PH_PAYLOAD)            early_status = npyhp_pkg::STAT_TRUNC;
    else                                     early_status = npyhp_pkg::STAT_OK;
  end

  assign start  = (major == 2'd1) ? 4'd10 : 4'd12;
  assign offset = 33'(hlen) + 33'(start);
  assign avail  = (bpos > 52'(offset)) ? bpos - 52'(offset) : 52'd0;

  always_comb begin
    case (dtc[1:0])
      2'd2:    avail_sh = avail >> 2;
      2'd3:    avail_sh = avail;
      default: avail_sh = avail >> 3;
    endcase
  end
  assign short_pay = (64'(prod) > 64'(avail_sh));

  // shift-add multiply of the running count by one dimension; also result status and index
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_status <= early_status;
      prod       <= COUNT_BITS'(1);
      idx        <= '0;
    end
    if (cmd.zero_prod) prod <= '0;
    if (cmd.mul_start) begin
      macc   <= '0;
      mc     <= MW'(prod);
      mplier <= rd;
    end
    if (cmd.mul_step) begin
      if (mplier[0]) macc <= macc + mc;
      mc     <= mc << 1;
      mplier <= mplier >> 1;
    end
    if (cmd.mul_commit) begin
      prod <= macc[COUNT_BITS-1:0];
      idx  <= idx + DW'(1);
    end
    if (cmd.count_err) res_status <= npyhp_pkg::STAT_COUNT;
    if (cmd.pay_check) begin
      res_status <= short_pay ? npyhp_pkg::STAT_PAYLOAD : npyhp_pkg::STAT_OK;
      idx        <= '0;
    end
    if (cmd.emit_next) idx <= idx + DW'(1);
  end

  assign dims7 = 7'(dims_seen);
  always_comb begin
    nres = (dims7 > 7'(npyhp_pkg::MAX_RESULTS)) ? 7'(npyhp_pkg::MAX_RESULTS) : dims7;
    if (nres == 7'd0) nres = 7'd1;
  end

  assign sts.early_bad = (early_status != npyhp_pkg::STAT_OK);
  assign sts.dim_end   = (idx == dims_seen);
  assign sts.dim_zero  = (rd == '0);
  assign sts.mul_done  = (mplier == '0);
  assign sts.mul_ovf   = (macc[MW-1:COUNT_BITS] != '0);
  assign sts.emit_last = (res_status != npyhp_pkg::STAT_OK) || (7'(idx) + 7'd1 == nres);

  assign dv64  = (idx < dims_seen) ? 64'(rd) : 64'd0;
  assign cnt64 = 64'(prod);

  always_comb begin
    result_data        = '0;
    result_data.status = res_status;
    if (res_status != npyhp_pkg::STAT_OK) begin
      result_data.last_result = 1'b1;
    end else begin
      result_data.dtype          = dtc[1:0];
      result_data.dim_count      = dims7[3:0];
      result_data.dim_index      = 3'(idx);
      result_data.dim_value      = dv64[31:0];
      result_data.element_count  = cnt64[47:0];
      result_data.payload_offset = offset;
      result_data.last_result    = sts.emit_last;
    end
  end

endmodule

// ===== src/npyhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// npyhp_ctrl
// Sequencer: byte intake, end-of-file count and payload checks, result beats.
// ----------------------------------------------------------------------------
module npyhp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic            byte_last,
  output logic            byte_stall,
  output logic            result_valid,
  input  logic            result_stall,
  input  npyhp_pkg::sts_t sts,
  output npyhp_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_PAY  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state, state_next;

  assign byte_stall   = (state != ST_RUN);
  assign result_valid = (state == ST_EMIT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_RUN: begin
        if (byte_valid) begin
          cmd.accept = 1'b1;
          if (byte_last) state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.early_bad ? ST_EMIT : ST_DIM;
      end
      ST_DIM: begin
        if (sts.dim_end) state_next = ST_PAY;
        else if (sts.dim_zero) begin
          cmd.zero_prod = 1'b1;
          state_next    = ST_PAY;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!sts.mul_done) cmd.mul_step = 1'b1;
        else if (sts.mul_ovf) begin
          cmd.count_err = 1'b1;
          state_next    = ST_EMIT;
        end else begin
          cmd.mul_commit = 1'b1;
          state_next     = ST_DIM;
        end
      end
      ST_PAY: begin
        cmd.pay_check = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!result_stall) begin
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_RUN;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_RUN;
    else     state <= state_next;
  end

endmodule

// ===== src/npy_header_parser.sv =====
// ----------------------------------------------------------------------------
// npy_header_parser
// Streaming NPY file header checker with per-dimension result beats.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------
//  byte     | in        | byte_valid / byte_stall     | data_byte, last_byte
//  result   | out       | result_valid / result_stall | status .. last_result
//
//  File bytes are taken one per cycle while byte_stall is low. After the last
//  byte: an evaluation state, then per shape dimension a setup state plus a
//  shift-add multiply, a payload-check state, then one result beat
//  per cycle that result_stall allows. The byte channel stalls from the last
//  byte until the final result beat is taken. rst is synchronous and leaves
//  the block ready for the first byte of a file.
// ----------------------------------------------------------------------------
module npy_header_parser #(
  parameter int MAX_DIMS   = 8,
  parameter int DIM_BITS   = 32,
  parameter int COUNT_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  npyhp_pkg::in_t   byte_data,
  output logic             result_valid,
  input  logic             result_stall,
  output npyhp_pkg::out_t  result_data
);

  npyhp_pkg::cmd_t cmd;
  npyhp_pkg::sts_t sts;

  npyhp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_last    (byte_data.last_byte),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  npyhp_dpath #(
    .MAX_DIMS   (MAX_DIMS),
    .DIM_BITS   (DIM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .byte_data   (byte_data),
    .cmd         (cmd),
    .sts         (sts),
    .result_data (result_data)
  );

  // no byte beat is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_stall)
    else $error("byte channel open while results pending");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.status != npyhp_pkg::STAT_OK) |-> result_data.last_result)
    else $error("error result not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.status != npyhp_pkg::STAT_OK) |->
      (result_data.element_count == '0 && result_data.payload_offset == '0))
    else $error("error result carries data");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && byte_data.last_byte) |=> byte_stall)
    else $error("byte accepted right after end of file");

endmodule
